[rtl/ipsp_pkg.sv]
// ----------------------------------------------------------------------------
// ipsp_pkg: shared types and constants of the IMU packet stream parser
// Holds register codes, reset values, group byte codes, quantity codes and
// the result and queue status types used between the parser parts.
// ----------------------------------------------------------------------------
package ipsp_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_ID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_ID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_ID    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ID    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DV_ID     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_MID  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA2_MID = 3'd6;

    // register reset values
    localparam logic [15:0] RST_QUAT_ID   = 16'h2010;
    localparam logic [15:0] RST_ACCEL_ID  = 16'h4020;
    localparam logic [15:0] RST_MAG_ID    = 16'hC020;
    localparam logic [15:0] RST_ROT_ID    = 16'h8020;
    localparam logic [15:0] RST_DV_ID     = 16'h4010;
    localparam logic [7:0]  RST_DATA_MID  = 8'h32;
    localparam logic [7:0]  RST_DATA2_MID = 8'h36;

    // packet id match mask and group bytes
    localparam logic [15:0] ID_MASK  = 16'hFFF0;
    localparam logic [7:0]  GRP_10   = 8'h10;
    localparam logic [7:0]  GRP_20   = 8'h20;
    localparam logic [7:0]  GRP_40   = 8'h40;
    localparam logic [7:0]  GRP_80   = 8'h80;
    localparam logic [7:0]  GRP_C0   = 8'hC0;
    localparam logic [7:0]  GRP_E0   = 8'hE0;

    // quantity codes
    localparam logic [2:0] KIND_QUAT  = 3'd0;
    localparam logic [2:0] KIND_ACCEL = 3'd1;
    localparam logic [2:0] KIND_MAG   = 3'd2;
    localparam logic [2:0] KIND_ROT   = 3'd3;
    localparam logic [2:0] KIND_DV    = 3'd4;
    localparam logic [2:0] KIND_NONE  = 3'd7;

    // words per vector
    localparam logic [5:0] WORDS_QUAT = 6'd4;
    localparam logic [5:0] WORDS_VEC  = 6'd3;

    // result queue between parser and output stage (power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  quantity;
        logic [1:0]  component;
        logic [31:0] word_value;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result item;
    } t_push;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    function automatic logic is_group(input logic [7:0] b);
        return (b == GRP_10) || (b == GRP_20) || (b == GRP_40) ||
               (b == GRP_80) || (b == GRP_C0) || (b == GRP_E0);
    endfunction

    // decrement, holding at zero
    function automatic logic [7:0] sat_dec(input logic [7:0] v);
        return (v == 8'd0) ? 8'd0 : v - 8'd1;
    endfunction

endpackage

[rtl/ipsp_in_if.sv]
// ----------------------------------------------------------------------------
// ipsp_in_if: byte input channel
// Carries one buffer byte per beat, the buffer length and the last-byte flag.
// ----------------------------------------------------------------------------
interface ipsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] frame_length;
    logic       end_of_buffer;

    modport source (output valid, data_byte, frame_length, end_of_buffer, input ready);
    modport sink   (input valid, data_byte, frame_length, end_of_buffer, output ready);
endinterface

[rtl/ipsp_out_if.sv]
// ----------------------------------------------------------------------------
// ipsp_out_if: result output channel
// Carries one measurement word per beat with its quantity and component.
// ----------------------------------------------------------------------------
interface ipsp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  quantity;
    logic [1:0]  component;
    logic [31:0] word_value;

    modport source (output valid, quantity, component, word_value, input ready);
    modport sink   (input valid, quantity, component, word_value, output ready);
endinterface

[rtl/ipsp_front.sv]
// ----------------------------------------------------------------------------
// ipsp_front: byte classifier and packet parser
// Holds the configuration registers, walks the buffer structure one byte per
// beat and pushes each complete matched payload word into the result queue.
// ----------------------------------------------------------------------------
module ipsp_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ipsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ipsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ipsp_in_if.sink                         i_in,
    input  ipsp_pkg::t_q_stat               i_q_stat,
    output ipsp_pkg::t_push                 o_push
);
    import ipsp_pkg::*;

    typedef enum logic [2:0] {
        PH_HEAD, PH_MSGLEN, PH_IDLO, PH_PLEN, PH_BODY, PH_STOP
    } t_phase;

    logic [15:0] r_quat_id, r_accel_id, r_mag_id, r_rot_id, r_dv_id;
    logic [7:0]  r_data_mid, r_data2_mid;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [7:0]  r_id_hi, n_id_hi;
    logic [7:0]  r_payload_left, n_payload_left;
    logic [7:0]  r_payload_index, n_payload_index;
    logic [23:0] r_word_bytes, n_word_bytes;
    logic [2:0]  r_kind, n_kind;
    logic        r_at_start, n_at_start;

    logic        w_accept;
    t_phase      w_phase;
    logic [7:0]  w_left;
    logic [15:0] w_id_masked;
    logic [2:0]  w_match;
    logic [5:0]  w_nwords;
    logic        w_emit;

    // take a byte whenever the queue has room for its possible result
    assign i_in.ready = !i_q_stat.full;
    assign w_accept   = i_in.valid && !i_q_stat.full;

    // first byte of a buffer restarts the walk with the new count
    assign w_phase = r_at_start ? PH_HEAD : r_phase;
    assign w_left  = r_at_start ? i_in.frame_length : r_bytes_left;

    // match the masked id, lowest quantity first
    assign w_id_masked = {r_id_hi, i_in.data_byte} & ID_MASK;
    always_comb begin
        if (w_id_masked == r_quat_id) begin
            w_match = KIND_QUAT;
        end else if (w_id_masked == r_accel_id) begin
            w_match = KIND_ACCEL;
        end else if (w_id_masked == r_mag_id) begin
            w_match = KIND_MAG;
        end else if (w_id_masked == r_rot_id) begin
            w_match = KIND_ROT;
        end else if (w_id_masked == r_dv_id) begin
            w_match = KIND_DV;
        end else begin
            w_match = KIND_NONE;
        end
    end

    // emit on the last byte of a complete word inside the vector
    assign w_nwords = (r_kind == KIND_QUAT) ? WORDS_QUAT : WORDS_VEC;
    assign w_emit   = w_accept && (w_phase == PH_BODY) && (r_payload_index[1:0] == 2'd3) &&
                      (r_kind != KIND_NONE) && (r_payload_index[7:2] < w_nwords);

    assign o_push.valid                = w_emit;
    assign o_push.item.quantity        = r_kind;
    assign o_push.item.component       = r_payload_index[3:2];
    assign o_push.item.word_value      = {r_word_bytes, i_in.data_byte};

    // next parse state
    always_comb begin
        n_phase         = r_phase;
        n_bytes_left    = r_bytes_left;
        n_id_hi         = r_id_hi;
        n_payload_left  = r_payload_left;
        n_payload_index = r_payload_index;
        n_word_bytes    = r_word_bytes;
        n_kind          = r_kind;
        n_at_start      = r_at_start;
        if (w_accept) begin
            n_at_start   = 1'b0;
            n_phase      = w_phase;
            n_bytes_left = w_left;
            unique case (w_phase)
                PH_HEAD: begin
                    if (w_left < 8'd2) begin
                        n_phase = PH_STOP;
                    end else if (is_group(i_in.data_byte)) begin
                        n_id_hi      = i_in.data_byte;
                        n_bytes_left = sat_dec(w_left);
                        n_phase      = PH_IDLO;
                    end else if (i_in.data_byte == r_data_mid ||
                                 i_in.data_byte == r_data2_mid) begin
                        n_bytes_left = sat_dec(w_left);
                        n_phase      = PH_MSGLEN;
                    end else begin
                        n_phase = PH_STOP;
                    end
                end
                PH_MSGLEN: begin
                    n_bytes_left = i_in.data_byte;
                    n_phase      = PH_HEAD;
                end
                PH_IDLO: begin
                    n_kind       = w_match;
                    n_bytes_left = sat_dec(w_left);
                    n_phase      = PH_PLEN;
                end
                PH_PLEN: begin
                    n_bytes_left    = sat_dec(w_left);
                    n_payload_left  = i_in.data_byte;
                    n_payload_index = 8'd0;
                    n_word_bytes    = 24'd0;
                    n_phase         = (i_in.data_byte == 8'd0) ? PH_HEAD : PH_BODY;
                end
                PH_BODY: begin
                    n_bytes_left    = sat_dec(w_left);
                    n_word_bytes    = (r_payload_index[1:0] == 2'd3) ? 24'd0 :
                                      {r_word_bytes[15:0], i_in.data_byte};
                    n_payload_index = r_payload_index + 8'd1;
                    n_payload_left  = r_payload_left - 8'd1;
                    if (r_payload_left == 8'd1) begin
                        n_phase = PH_HEAD;
                    end
                end
                default: begin
                    n_phase = PH_STOP;
                end
            endcase
            // drop all parse state after the last byte of a buffer
            if (i_in.end_of_buffer) begin
                n_phase         = PH_HEAD;
                n_bytes_left    = 8'd0;
                n_id_hi         = 8'd0;
                n_payload_left  = 8'd0;
                n_payload_index = 8'd0;
                n_word_bytes    = 24'd0;
                n_kind          = KIND_NONE;
                n_at_start      = 1'b1;
            end
        end
    end

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat_id   <= RST_QUAT_ID;
            r_accel_id  <= RST_ACCEL_ID;
            r_mag_id    <= RST_MAG_ID;
            r_rot_id    <= RST_ROT_ID;
            r_dv_id     <= RST_DV_ID;
            r_data_mid  <= RST_DATA_MID;
            r_data2_mid <= RST_DATA2_MID;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QUAT_ID:   r_quat_id   <= i_cfg_data;
                CFG_ACCEL_ID:  r_accel_id  <= i_cfg_data;
                CFG_MAG_ID:    r_mag_id    <= i_cfg_data;
                CFG_ROT_ID:    r_rot_id    <= i_cfg_data;
                CFG_DV_ID:     r_dv_id     <= i_cfg_data;
                CFG_DATA_MID:  r_data_mid  <= i_cfg_data[7:0];
                CFG_DATA2_MID: r_data2_mid <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // hold parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HEAD;
            r_bytes_left    <= 8'd0;
            r_id_hi         <= 8'd0;
            r_payload_left  <= 8'd0;
            r_payload_index <= 8'd0;
            r_word_bytes    <= 24'd0;
            r_kind          <= KIND_NONE;
            r_at_start      <= 1'b1;
        end else begin
            r_phase         <= n_phase;
            r_bytes_left    <= n_bytes_left;
            r_id_hi         <= n_id_hi;
            r_payload_left  <= n_payload_left;
            r_payload_index <= n_payload_index;
            r_word_bytes    <= n_word_bytes;
            r_kind          <= n_kind;
            r_at_start      <= n_at_start;
        end
    end

    // results come only from payload bytes of a matched packet
    a_emit_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> (r_phase == PH_BODY && !r_at_start && r_kind != KIND_NONE))
        else $error("result pushed outside a matched payload");

    // the last byte of a buffer rearms the count load
    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.end_of_buffer) |=> (r_at_start && r_phase == PH_HEAD))
        else $error("parser did not return to start after last byte");

    // a byte is never taken while the queue is full
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_stat.full |-> !o_push.valid)
        else $error("push into a full queue");

endmodule

[rtl/ipsp_queue.sv]
// ----------------------------------------------------------------------------
// ipsp_queue: result queue between parser and output stage
// Small register FIFO so the parser and the output stage stall independently.
// ----------------------------------------------------------------------------
module ipsp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ipsp_pkg::t_push   i_push,
    input  logic              i_pop,
    output ipsp_pkg::t_result o_head,
    output ipsp_pkg::t_q_stat o_stat
);
    import ipsp_pkg::*;

    t_result                r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   w_push, w_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign w_push       = i_push.valid && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    // store pushed entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from an empty queue");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QUEUE_CNT_W'(QUEUE_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

[rtl/ipsp_back.sv]
// ----------------------------------------------------------------------------
// ipsp_back: output stage
// Holds one result in an output register and refills it from the queue on the
// beat it is taken, so one result can leave every cycle while the queue is not empty.
// ----------------------------------------------------------------------------
module ipsp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ipsp_pkg::t_result i_head,
    input  ipsp_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    ipsp_out_if.source        o_out
);
    import ipsp_pkg::*;

    logic    r_valid;
    t_result r_item;

    // load when the register is empty or being emptied this cycle
    assign o_pop = !i_q_stat.empty && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_out.ready) begin
            r_valid <= !i_q_stat.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.quantity   = r_item.quantity;
    assign o_out.component  = r_item.component;
    assign o_out.word_value = r_item.word_value;

    // a pending queue entry reaches the register once it frees up
    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_q_stat.empty && !r_valid) |=> r_valid)
        else $error("output register not refilled from queue");

endmodule

[rtl/imu_packet_stream_parser_core.sv]
// ----------------------------------------------------------------------------
// imu_packet_stream_parser_core: IMU measurement buffer parser
// Usage:
//   i_in_bus takes one buffer byte per beat; frame_length is sampled on the
//   first byte of a buffer and end_of_buffer flags its last byte, after which
//   the next byte starts a new buffer.
//   o_out_bus gives one 32-bit measurement word per beat with its quantity
//   and component, in buffer order.
//   The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes the five
//   packet ids and two message ids; write only while the block is idle.
// Timing:
//   One byte is accepted every cycle while the result queue has room. A
//   result goes to o_out_bus through the queue and the output register:
//   the parser pushes it into a four-entry queue at the accepting edge and
//   the output register loads it from the queue once the register is free.
//   One result can leave per cycle.
// Reset and stall:
//   Synchronous reset restores the register defaults, empties the queue and
//   arms the parser for a new buffer. When the receiver stalls, results wait
//   in the output register and the queue; input bytes keep flowing until the
//   queue fills, then i_in_bus.ready drops.
// ----------------------------------------------------------------------------
module imu_packet_stream_parser_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ipsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ipsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ipsp_in_if.sink                         i_in_bus,
    ipsp_out_if.source                      o_out_bus
);
    import ipsp_pkg::*;

    t_push   w_push;
    t_result w_head;
    t_q_stat w_q_stat;
    logic    w_pop;

    ipsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in_bus),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push)
    );

    ipsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    ipsp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out_bus)
    );

endmodule

[dv/imu_packet_stream_parser_core_tb.sv]
// ----------------------------------------------------------------------------
// imu_packet_stream_parser_core_tb: self-checking bench for the buffer parser
// Feeds measurement buffers byte by byte, predicts every emitted word with a
// cycle-free model of the parser and checks each output beat in order, while
// both channels idle and stall at random and the id registers are reprogrammed
// between traffic phases.
// ----------------------------------------------------------------------------
module imu_packet_stream_parser_core_tb;
    import ipsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PRINT_LIMIT    = 100;
    localparam int PICK_UNMATCHED = 5;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    // Word predictor and in-order store of the words still to come
    class imu_word_tracker;
        typedef enum logic [2:0] {
            AWAIT_HEAD, AWAIT_MSG_LEN, AWAIT_ID_LO, AWAIT_PLEN, IN_PAYLOAD, HALTED
        } t_parse_at;

        t_result     pending_words[$];
        int unsigned mismatches;
        logic [15:0] kind_id[5];
        logic [7:0]  msg_id_a;
        logic [7:0]  msg_id_b;

        t_parse_at   parse_at;
        logic [7:0]  count_left;
        logic [15:0] pkt_id;
        logic [7:0]  body_left;
        logic [7:0]  body_pos;
        logic [23:0] partial_word;
        logic [2:0]  kind;
        bit          fresh;

        function new();
            kind_id[KIND_QUAT]  = RST_QUAT_ID;
            kind_id[KIND_ACCEL] = RST_ACCEL_ID;
            kind_id[KIND_MAG]   = RST_MAG_ID;
            kind_id[KIND_ROT]   = RST_ROT_ID;
            kind_id[KIND_DV]    = RST_DV_ID;
            msg_id_a   = RST_DATA_MID;
            msg_id_b   = RST_DATA2_MID;
            mismatches = 0;
            restart();
        endfunction

        // arm for a new buffer, registers untouched
        function void restart();
            parse_at     = AWAIT_HEAD;
            count_left   = '0;
            pkt_id       = '0;
            body_left    = '0;
            body_pos     = '0;
            partial_word = '0;
            kind         = KIND_NONE;
            fresh        = 1'b1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_QUAT_ID:   kind_id[KIND_QUAT]  = data;
                CFG_ACCEL_ID:  kind_id[KIND_ACCEL] = data;
                CFG_MAG_ID:    kind_id[KIND_MAG]   = data;
                CFG_ROT_ID:    kind_id[KIND_ROT]   = data;
                CFG_DV_ID:     kind_id[KIND_DV]    = data;
                CFG_DATA_MID:  msg_id_a = data[7:0];
                CFG_DATA2_MID: msg_id_b = data[7:0];
                default: ;
            endcase
        endfunction

        // lowest quantity number wins on equal ids
        function logic [2:0] lookup_kind(logic [15:0] id);
            logic [15:0] masked;
            masked = id & ID_MASK;
            if (masked == kind_id[KIND_QUAT])  return KIND_QUAT;
            if (masked == kind_id[KIND_ACCEL]) return KIND_ACCEL;
            if (masked == kind_id[KIND_MAG])   return KIND_MAG;
            if (masked == kind_id[KIND_ROT])   return KIND_ROT;
            if (masked == kind_id[KIND_DV])    return KIND_DV;
            return KIND_NONE;
        endfunction

        // count down, holding at zero
        function void use_one();
            if (count_left != 8'd0)
                count_left--;
        endfunction

        function void take_byte(logic [7:0] b, logic [7:0] flen, logic is_last);
            logic [5:0] word_no;
            logic [5:0] word_cnt;
            t_result    w;
            if (fresh) begin
                count_left = flen;
                fresh      = 1'b0;
                parse_at   = AWAIT_HEAD;
            end
            case (parse_at)
                AWAIT_HEAD: begin
                    if (count_left < 8'd2) begin
                        parse_at = HALTED;
                    end else if (b inside {GRP_10, GRP_20, GRP_40, GRP_80, GRP_C0, GRP_E0}) begin
                        pkt_id   = {b, 8'h00};
                        use_one();
                        parse_at = AWAIT_ID_LO;
                    end else if (b == msg_id_a || b == msg_id_b) begin
                        use_one();
                        parse_at = AWAIT_MSG_LEN;
                    end else begin
                        parse_at = HALTED;
                    end
                end
                AWAIT_MSG_LEN: begin
                    count_left = b;
                    parse_at   = AWAIT_HEAD;
                end
                AWAIT_ID_LO: begin
                    pkt_id[7:0] = b;
                    kind        = lookup_kind(pkt_id);
                    use_one();
                    parse_at    = AWAIT_PLEN;
                end
                AWAIT_PLEN: begin
                    use_one();
                    body_left    = b;
                    body_pos     = '0;
                    partial_word = '0;
                    parse_at     = (b == 8'd0) ? AWAIT_HEAD : IN_PAYLOAD;
                end
                IN_PAYLOAD: begin
                    word_no  = body_pos[7:2];
                    word_cnt = (kind == KIND_QUAT) ? WORDS_QUAT : WORDS_VEC;
                    use_one();
                    // emit only whole words that fall within the vector
                    if (body_pos[1:0] == 2'd3) begin
                        if (kind != KIND_NONE && word_no < word_cnt) begin
                            w.quantity   = kind;
                            w.component  = word_no[1:0];
                            w.word_value = {partial_word, b};
                            pending_words.push_back(w);
                        end
                        partial_word = '0;
                    end else begin
                        partial_word = {partial_word[15:0], b};
                    end
                    body_pos++;
                    body_left--;
                    if (body_left == 8'd0)
                        parse_at = AWAIT_HEAD;
                end
                default: parse_at = HALTED;
            endcase
            if (is_last)
                restart();
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        // compare one output beat against the oldest expected word
        task check_word(logic [2:0] quantity, logic [1:0] component, logic [31:0] value);
            t_result exp;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word q=%0d c=%0d v=%08h",
                                          quantity, component, value));
            end else begin
                exp = pending_words.pop_front();
                if (quantity !== exp.quantity)
                    report_mismatch($sformatf("quantity %0d, expected %0d",
                                              quantity, exp.quantity));
                if (component !== exp.component)
                    report_mismatch($sformatf("component %0d, expected %0d",
                                              component, exp.component));
                if (value !== exp.word_value)
                    report_mismatch($sformatf("word %08h, expected %08h",
                                              value, exp.word_value));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ipsp_in_if  in_bus();
    ipsp_out_if out_bus();

    imu_packet_stream_parser_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_bus   (in_bus),
        .o_out_bus  (out_bus)
    );

    imu_word_tracker words_sb;
    logic [7:0]      frame_bytes[$];
    logic [15:0]     next_ids[5];
    logic [7:0]      next_mid_a;
    logic [7:0]      next_mid_b;
    int unsigned     bytes_sent;
    int unsigned     burst_left;
    int unsigned     quiet_cycles;
    bit              gaps_off;
    bit              long_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Observe accepted beats on both channels, and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n && in_bus.valid && in_bus.ready)
            words_sb.take_byte(in_bus.data_byte, in_bus.frame_length, in_bus.end_of_buffer);
        if (i_rst_n && out_bus.valid && out_bus.ready)
            words_sb.check_word(out_bus.quantity, out_bus.component, out_bus.word_value);
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: stall in stretches of changing style, with one long hold-off
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   out_bus.ready <= 1'b1;
                    RX_COIN:   out_bus.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_bus.ready <= ($urandom_range(0, 3) == 0);
                    default:   out_bus.ready <= !out_bus.ready;
                endcase
            end
        end
    end

    // Offer one byte, opening a random gap when a burst runs out
    task send_byte(logic [7:0] b, logic [7:0] flen, logic is_last);
        int gap;
        if (!gaps_off && burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        in_bus.valid         <= 1'b1;
        in_bus.data_byte     <= b;
        in_bus.frame_length  <= flen;
        in_bus.end_of_buffer <= is_last;
        do @(posedge i_clk); while (!in_bus.ready);
        bytes_sent++;
    endtask

    // Send the built buffer; the length field only counts on the first beat
    task send_frame(logic [7:0] flen);
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], (i == 0) ? flen : 8'($urandom),
                      i == frame_bytes.size() - 1);
    endtask

    // Hold the channel idle until every expected word is out
    task settle();
        in_bus.valid <= 1'b0;
        while (words_sb.pending_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        words_sb.set_reg(idx, data);
    endtask

    // Write all seven registers; message ids carry junk in the upper byte
    task program_regs();
        put_reg(CFG_QUAT_ID,   next_ids[KIND_QUAT]);
        put_reg(CFG_ACCEL_ID,  next_ids[KIND_ACCEL]);
        put_reg(CFG_MAG_ID,    next_ids[KIND_MAG]);
        put_reg(CFG_ROT_ID,    next_ids[KIND_ROT]);
        put_reg(CFG_DV_ID,     next_ids[KIND_DV]);
        put_reg(CFG_DATA_MID,  {8'($urandom), next_mid_a});
        put_reg(CFG_DATA2_MID, {8'($urandom), next_mid_b});
        i_cfg_we <= 1'b0;
    endtask

    function logic [7:0] pick_group();
        case ($urandom_range(0, 5))
            0:       return GRP_10;
            1:       return GRP_20;
            2:       return GRP_40;
            3:       return GRP_80;
            4:       return GRP_C0;
            default: return GRP_E0;
        endcase
    endfunction

    // Mostly parseable ids, some duplicates, some with low bits set
    task randomize_regs();
        int r;
        for (int k = 0; k < 5; k++) begin
            r = $urandom_range(0, 9);
            if (r < 7)
                next_ids[k] = {pick_group(), 8'($urandom) & 8'hF0};
            else if (r < 8 && k > 0)
                next_ids[k] = next_ids[$urandom_range(0, k - 1)];
            else
                next_ids[k] = 16'($urandom);
        end
        next_mid_a = ($urandom_range(0, 3) == 0) ? pick_group() : 8'($urandom);
        next_mid_b = 8'($urandom);
        program_regs();
    endtask

    task set_all_regs(logic [15:0] id, logic [7:0] mid_a, logic [7:0] mid_b);
        foreach (next_ids[k])
            next_ids[k] = id;
        next_mid_a = mid_a;
        next_mid_b = mid_b;
        program_regs();
    endtask

    // Append a packet: a configured quantity, or a random group and id
    task add_packet(int sel);
        logic [15:0] id;
        int          plen;
        int          r;
        if (sel < PICK_UNMATCHED)
            id = words_sb.kind_id[sel] | 16'($urandom_range(0, 15));
        else
            id = {pick_group(), 8'($urandom)};
        r = $urandom_range(0, 9);
        if (r < 6)
            plen = (sel == KIND_QUAT) ? 16 : 12;
        else
            plen = $urandom_range(0, 24);
        frame_bytes.push_back(id[15:8]);
        frame_bytes.push_back(id[7:0]);
        frame_bytes.push_back(8'(plen));
        repeat (plen) begin
            r = $urandom_range(0, 7);
            frame_bytes.push_back((r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom));
        end
    endtask

    // Build a well-formed buffer (optionally wrapped in a data message) or noise
    task build_frame(output logic [7:0] flen);
        int body_size;
        frame_bytes.delete();
        if ($urandom_range(0, 3) != 0) begin
            repeat ($urandom_range(1, 3)) add_packet($urandom_range(0, PICK_UNMATCHED));
            if ($urandom_range(0, 1) == 1) begin
                body_size = frame_bytes.size();
                frame_bytes.push_front(8'(body_size));
                frame_bytes.push_front(($urandom_range(0, 1) == 1) ? words_sb.msg_id_a
                                                                   : words_sb.msg_id_b);
            end
            flen = ($urandom_range(0, 7) != 0) ? 8'(frame_bytes.size())
                                               : 8'($urandom_range(0, frame_bytes.size()));
        end else begin
            repeat ($urandom_range(1, 10)) begin
                case ($urandom_range(0, 2))
                    0:       frame_bytes.push_back(pick_group());
                    1:       frame_bytes.push_back(words_sb.msg_id_a);
                    default: frame_bytes.push_back(8'($urandom));
                endcase
            end
            flen = 8'($urandom);
        end
    endtask

    task run_random(int unsigned n_bytes);
        int unsigned stop_at;
        logic [7:0]  flen;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            build_frame(flen);
            send_frame(flen);
        end
    endtask

    initial begin
        words_sb      = new();
        bytes_sent    = 0;
        burst_left    = 0;
        quiet_cycles  = 0;
        gaps_off      = 1'b0;
        long_hold_req = 1'b0;
        in_bus.valid         <= 1'b0;
        in_bus.data_byte     <= '0;
        in_bus.frame_length  <= '0;
        in_bus.end_of_buffer <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        i_rst_n    <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // duplicate accel id on dv, dv must lose; rot id with low bits set;
        // second message id equal to a group byte
        put_reg(CFG_DV_ID, RST_ACCEL_ID);
        put_reg(CFG_ROT_ID, 16'h8021);
        put_reg(CFG_DATA2_MID, {8'h00, GRP_20});
        i_cfg_we <= 1'b0;

        // nested body, one whole accel word plus a partial one, empty mag packet
        frame_bytes = {RST_DATA_MID, 8'h0C, GRP_40, 8'h2F, 8'h06,
                       8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, GRP_C0, 8'h20, 8'h00};
        send_frame(8'hFF);
        // no room for an item
        frame_bytes = {GRP_10};
        send_frame(8'h00);
        // unknown leading byte
        frame_bytes = {8'h55, 8'hAA};
        send_frame(8'h06);
        // group wins over message id; payload runs past the count, then too few left
        frame_bytes = {GRP_20, 8'h1F, 8'h04, 8'h01, 8'h02, 8'h03, 8'h04, GRP_40};
        send_frame(8'h04);
        // id with no match
        frame_bytes = {GRP_80, 8'h2A, 8'h04, 8'h11, 8'h22, 8'h33, 8'h44};
        send_frame(8'h07);
        settle();

        // reset values, then a long output hold-off under back-to-back quaternions
        next_ids[KIND_QUAT]  = RST_QUAT_ID;
        next_ids[KIND_ACCEL] = RST_ACCEL_ID;
        next_ids[KIND_MAG]   = RST_MAG_ID;
        next_ids[KIND_ROT]   = RST_ROT_ID;
        next_ids[KIND_DV]    = RST_DV_ID;
        next_mid_a = RST_DATA_MID;
        next_mid_b = RST_DATA2_MID;
        program_regs();
        long_hold_req = 1'b1;
        gaps_off      = 1'b1;
        repeat (3) begin
            frame_bytes.delete();
            repeat (3) add_packet(KIND_QUAT);
            send_frame(8'(frame_bytes.size()));
        end
        gaps_off = 1'b0;
        run_random(170);
        settle();

        randomize_regs();
        run_random(170);
        settle();

        set_all_regs(16'h0000, 8'h00, 8'hFF);
        run_random(40);
        settle();

        set_all_regs(16'hFFFF, 8'hFF, 8'h00);
        run_random(40);
        settle();

        randomize_regs();
        run_random(170);
        settle();

        randomize_regs();
        run_random(170);
        settle();

        if (words_sb.pending_words.size() != 0)
            words_sb.report_mismatch($sformatf("%0d words never arrived",
                                               words_sb.pending_words.size()));
        if (words_sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
